[rtl/spd_pkg.sv]
// Shared constants for the segment pair distance block.
// No dependencies; used by the top level, spd_lane and the checker.
package spd_pkg;

   localparam int DEF_COORD_BITS = 12;
   localparam int DEF_FRAC_BITS  = 4;

endpackage

[rtl/segment_pair_distance.sv]
// Segment pair distance: the smallest endpoint-to-segment distance between two segments.
// Depends on spd_pkg and spd_lane.
//
// Each transaction carries two segments; the block returns floor(2^FRAC_BITS * d), where d
// is the smallest of the four distances from an endpoint of one segment to the other
// segment. Crossing segments are not detected. One transaction is taken every cycle
// while req_ready is high; each result passes through the bit-per-stage divider and
// square root in each of the four distance lanes and then a registered minimum tree.
// A stalled result goes to a one-entry skid buffer, and the pipeline holds only while
// that buffer is occupied.
module segment_pair_distance #(
   parameter int COORD_BITS = spd_pkg::DEF_COORD_BITS,
   parameter int FRAC_BITS  = spd_pkg::DEF_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [COORD_BITS-1:0]         req_first_start_x,
   input  logic [COORD_BITS-1:0]         req_first_start_y,
   input  logic [COORD_BITS-1:0]         req_first_end_x,
   input  logic [COORD_BITS-1:0]         req_first_end_y,
   input  logic [COORD_BITS-1:0]         req_second_start_x,
   input  logic [COORD_BITS-1:0]         req_second_start_y,
   input  logic [COORD_BITS-1:0]         req_second_end_x,
   input  logic [COORD_BITS-1:0]         req_second_end_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [COORD_BITS+FRAC_BITS:0] rsp_min_distance
);

   localparam int OW  = COORD_BITS + FRAC_BITS + 1;
   localparam int LAT = 6 + (2 * COORD_BITS + 2 * FRAC_BITS + 1) + OW;
   localparam int VL  = LAT + 2;

   logic          en;
   logic [OW-1:0] d0, d1, d2, d3;
   logic [OW-1:0] m01_ff, m23_ff, best_ff;
   logic [VL-1:0] vpipe_ff;
   logic          emit, take;
   logic          out_valid_ff, skid_full_ff;
   logic [OW-1:0] out_data_ff, skid_data_ff;

   assign en        = !skid_full_ff;
   assign req_ready = en;

   spd_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane0 (
      .clock(clock), .en(en),
      .px(req_first_start_x), .py(req_first_start_y),
      .ax(req_second_start_x), .ay(req_second_start_y),
      .bx(req_second_end_x), .by(req_second_end_y),
      .seg_dist(d0)
   );

   spd_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane1 (
      .clock(clock), .en(en),
      .px(req_first_end_x), .py(req_first_end_y),
      .ax(req_second_start_x), .ay(req_second_start_y),
      .bx(req_second_end_x), .by(req_second_end_y),
      .seg_dist(d1)
   );

   spd_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane2 (
      .clock(clock), .en(en),
      .px(req_second_start_x), .py(req_second_start_y),
      .ax(req_first_start_x), .ay(req_first_start_y),
      .bx(req_first_end_x), .by(req_first_end_y),
      .seg_dist(d2)
   );

   spd_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane3 (
      .clock(clock), .en(en),
      .px(req_second_end_x), .py(req_second_end_y),
      .ax(req_first_start_x), .ay(req_first_start_y),
      .bx(req_first_end_x), .by(req_first_end_y),
      .seg_dist(d3)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         m01_ff  <= (d1 < d0) ? d1 : d0;
         m23_ff  <= (d3 < d2) ? d3 : d2;
         best_ff <= (m23_ff < m01_ff) ? m23_ff : m01_ff;
      end
   end

   assign emit = en && vpipe_ff[VL-1];
   assign take = out_valid_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vpipe_ff     <= '0;
         out_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         if (en) begin
            vpipe_ff <= {vpipe_ff[VL-2:0], req_valid};
         end
         if (skid_full_ff) begin
            if (take) begin
               out_data_ff  <= skid_data_ff;
               skid_full_ff <= 1'b0;
            end
         end else if (emit) begin
            if (!out_valid_ff || take) begin
               out_data_ff  <= best_ff;
               out_valid_ff <= 1'b1;
            end else begin
               skid_data_ff <= best_ff;
               skid_full_ff <= 1'b1;
            end
         end else if (take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_min_distance = out_data_ff;

endmodule

[rtl/spd_lane.sv]
// One point-to-segment distance pipeline: the distance from point p to segment a-b.
// Depends on spd_pkg for its default widths; instantiated four times by segment_pair_distance.
module spd_lane #(
   parameter int COORD_BITS = spd_pkg::DEF_COORD_BITS,
   parameter int FRAC_BITS  = spd_pkg::DEF_FRAC_BITS
) (
   input  logic                            clock,
   input  logic                            en,
   input  logic [COORD_BITS-1:0]           px,
   input  logic [COORD_BITS-1:0]           py,
   input  logic [COORD_BITS-1:0]           ax,
   input  logic [COORD_BITS-1:0]           ay,
   input  logic [COORD_BITS-1:0]           bx,
   input  logic [COORD_BITS-1:0]           by,
   output logic [COORD_BITS+FRAC_BITS:0]   seg_dist
);

   localparam int DIFW = COORD_BITS + 1;
   localparam int PRW  = 2 * COORD_BITS + 2;
   localparam int DW   = 2 * COORD_BITS + 1;
   localparam int CW   = 2 * COORD_BITS + 1;
   localparam int CSW  = 2 * CW;
   localparam int NW   = CSW + 2 * FRAC_BITS;
   localparam int QW   = 2 * COORD_BITS + 2 * FRAC_BITS + 1;
   localparam int RW   = COORD_BITS + FRAC_BITS + 1;
   localparam int SRW  = RW + 3;

   // Input capture.
   logic [COORD_BITS-1:0] px_ff, py_ff, ax_ff, ay_ff, bx_ff, by_ff;
   // Differences.
   logic signed [DIFW-1:0] dx_ff, dy_ff, ex_ff, ey_ff, fx_ff, fy_ff;
   // Products.
   logic signed [PRW-1:0] dxdx_ff, dydy_ff, exdx_ff, eydy_ff, exdy_ff, eydx_ff;
   logic signed [PRW-1:0] exex_ff, eyey_ff, fxfx_ff, fyfy_ff;
   // Sums.
   logic [DW-1:0]          len2_ff, sqe_ff, sqf_ff;
   logic signed [PRW-1:0]  dot_ff, cross_ff;
   // Case selection.
   logic                   perp3_ff;
   logic [DW-1:0]          sqm3_ff, den3_ff;
   logic [CW-1:0]          c3_ff;
   // Squared cross product.
   logic                   perp4_ff;
   logic [DW-1:0]          sqm4_ff, den4_ff;
   logic [CSW-1:0]         csq_ff;

   // Long division stages.
   logic [DW-1:0] div_rem_ff  [QW];
   logic [QW-1:0] div_low_ff  [QW];
   logic [QW-1:0] div_q_ff    [QW];
   logic [DW-1:0] div_den_ff  [QW];
   logic [DW-1:0] div_sqm_ff  [QW];
   logic          div_perp_ff [QW];
   logic [DW-1:0] div_rem_in  [QW];
   logic [QW-1:0] div_low_in  [QW];
   logic [QW-1:0] div_q_in    [QW];
   logic [DW-1:0] div_den_in  [QW];
   logic [DW-1:0] div_sqm_in  [QW];
   logic          div_perp_in [QW];

   // Square root stages.
   logic [SRW-1:0]  sq_rem_ff  [RW];
   logic [RW-1:0]   sq_root_ff [RW];
   logic [2*RW-1:0] sq_val_ff  [RW];
   logic [SRW-1:0]  sq_rem_in  [RW];
   logic [RW-1:0]   sq_root_in [RW];
   logic [2*RW-1:0] sq_val_in  [RW];

   logic [NW-1:0] num_scaled;
   logic [QW-1:0] root_arg;

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= px;
         py_ff <= py;
         ax_ff <= ax;
         ay_ff <= ay;
         bx_ff <= bx;
         by_ff <= by;

         dx_ff <= $signed({1'b0, bx_ff}) - $signed({1'b0, ax_ff});
         dy_ff <= $signed({1'b0, by_ff}) - $signed({1'b0, ay_ff});
         ex_ff <= $signed({1'b0, px_ff}) - $signed({1'b0, ax_ff});
         ey_ff <= $signed({1'b0, py_ff}) - $signed({1'b0, ay_ff});
         fx_ff <= $signed({1'b0, px_ff}) - $signed({1'b0, bx_ff});
         fy_ff <= $signed({1'b0, py_ff}) - $signed({1'b0, by_ff});

         dxdx_ff <= PRW'(dx_ff * dx_ff);
         dydy_ff <= PRW'(dy_ff * dy_ff);
         exdx_ff <= PRW'(ex_ff * dx_ff);
         eydy_ff <= PRW'(ey_ff * dy_ff);
         exdy_ff <= PRW'(ex_ff * dy_ff);
         eydx_ff <= PRW'(ey_ff * dx_ff);
         exex_ff <= PRW'(ex_ff * ex_ff);
         eyey_ff <= PRW'(ey_ff * ey_ff);
         fxfx_ff <= PRW'(fx_ff * fx_ff);
         fyfy_ff <= PRW'(fy_ff * fy_ff);

         len2_ff  <= DW'(dxdx_ff + dydy_ff);
         sqe_ff   <= DW'(exex_ff + eyey_ff);
         sqf_ff   <= DW'(fxfx_ff + fyfy_ff);
         dot_ff   <= exdx_ff + eydy_ff;
         cross_ff <= exdy_ff - eydx_ff;

         // A degenerate segment or a projection before the start measures to the start,
         // a projection past the end measures to the end, otherwise the perpendicular.
         if (len2_ff == '0 || dot_ff <= 0) begin
            perp3_ff <= 1'b0;
            sqm3_ff  <= sqe_ff;
         end else if (dot_ff >= $signed({1'b0, len2_ff})) begin
            perp3_ff <= 1'b0;
            sqm3_ff  <= sqf_ff;
         end else begin
            perp3_ff <= 1'b1;
            sqm3_ff  <= sqe_ff;
         end
         c3_ff   <= (cross_ff < 0) ? CW'(-cross_ff) : CW'(cross_ff);
         den3_ff <= len2_ff;

         perp4_ff <= perp3_ff;
         sqm4_ff  <= sqm3_ff;
         den4_ff  <= den3_ff;
         csq_ff   <= CSW'(c3_ff * c3_ff);

         for (int k = 0; k < QW; k++) begin
            div_rem_ff[k]  <= div_rem_in[k];
            div_low_ff[k]  <= div_low_in[k];
            div_q_ff[k]    <= div_q_in[k];
            div_den_ff[k]  <= div_den_in[k];
            div_sqm_ff[k]  <= div_sqm_in[k];
            div_perp_ff[k] <= div_perp_in[k];
         end

         for (int k = 0; k < RW; k++) begin
            sq_rem_ff[k]  <= sq_rem_in[k];
            sq_root_ff[k] <= sq_root_in[k];
            sq_val_ff[k]  <= sq_val_in[k];
         end
      end
   end

   assign num_scaled = NW'(csq_ff) << (2 * FRAC_BITS);

   // Restoring division of cross^2 * 4^FRAC_BITS by the squared length, one quotient
   // bit per stage. The quotient is known to fit in QW bits whenever it is used.
   always_comb begin
      logic [DW-1:0] s_rem;
      logic [QW-1:0] s_low;
      logic [QW-1:0] s_q;
      logic [DW-1:0] s_den;
      logic [DW:0]   trial;
      logic          ge;
      for (int k = 0; k < QW; k++) begin
         if (k == 0) begin
            s_rem = num_scaled[NW-1:QW];
            s_low = num_scaled[QW-1:0];
            s_q   = '0;
            s_den = den4_ff;
            div_sqm_in[k]  = sqm4_ff;
            div_perp_in[k] = perp4_ff;
         end else begin
            s_rem = div_rem_ff[k-1];
            s_low = div_low_ff[k-1];
            s_q   = div_q_ff[k-1];
            s_den = div_den_ff[k-1];
            div_sqm_in[k]  = div_sqm_ff[k-1];
            div_perp_in[k] = div_perp_ff[k-1];
         end
         trial = {s_rem, s_low[QW-1]};
         ge    = trial >= {1'b0, s_den};
         div_rem_in[k] = ge ? DW'(trial - {1'b0, s_den}) : DW'(trial);
         div_low_in[k] = s_low << 1;
         div_q_in[k]   = {s_q[QW-2:0], ge};
         div_den_in[k] = s_den;
      end
   end

   assign root_arg = div_perp_ff[QW-1] ? div_q_ff[QW-1]
                                       : (QW'(div_sqm_ff[QW-1]) << (2 * FRAC_BITS));

   // Digit-by-digit integer square root, one root bit per stage.
   always_comb begin
      logic [SRW-1:0]  s_rem;
      logic [RW-1:0]   s_root;
      logic [2*RW-1:0] s_val;
      logic [SRW-1:0]  r;
      logic [SRW-1:0]  t;
      logic            ge;
      for (int k = 0; k < RW; k++) begin
         if (k == 0) begin
            s_rem  = '0;
            s_root = '0;
            s_val  = {1'b0, root_arg};
         end else begin
            s_rem  = sq_rem_ff[k-1];
            s_root = sq_root_ff[k-1];
            s_val  = sq_val_ff[k-1];
         end
         r  = {s_rem[SRW-3:0], s_val[2*RW-1:2*RW-2]};
         t  = SRW'({s_root, 2'b01});
         ge = r >= t;
         sq_rem_in[k]  = ge ? (r - t) : r;
         sq_root_in[k] = {s_root[RW-2:0], ge};
         sq_val_in[k]  = s_val << 2;
      end
   end

   assign seg_dist = sq_root_ff[RW-1];

endmodule

[rtl/spd_check.sv]
// Port-level checker for segment_pair_distance, attached by the bind at the end.
// Depends on spd_pkg for its default widths.
module spd_check #(
   parameter int COORD_BITS = spd_pkg::DEF_COORD_BITS,
   parameter int FRAC_BITS  = spd_pkg::DEF_FRAC_BITS
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [COORD_BITS+FRAC_BITS:0] rsp_min_distance
);

   // Reset empties the output stage.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result keeps its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_min_distance))
      else $error("stalled result changed");

   // The input side only stalls after the output side refused a transaction.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> $past(rsp_valid && !rsp_ready))
      else $error("input stalled without an output stall");

   // A taken result always ends an input stall.
   a_stall_release: assert property (@(posedge clock) disable iff (reset)
      !req_ready && rsp_ready |=> req_ready)
      else $error("input stall outlasted a taken result");

endmodule

bind segment_pair_distance spd_check #(
   .COORD_BITS(COORD_BITS),
   .FRAC_BITS(FRAC_BITS)
) u_spd_check (
   .clock(clock),
   .reset(reset),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_min_distance(rsp_min_distance)
);
